// ----- sv/edsc_pkg.sv -----
package edsc_pkg;

  localparam int COUNT_WIDTH = 16;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [1:0] {
    KIND_ENC  = 2'd0,
    KIND_BTN  = 2'd1,
    KIND_TICK = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RUN_POSITION = 2'd0,
    RUN_CW       = 2'd1,
    RUN_CCW      = 2'd2,
    RUN_STOP     = 2'd3
  } run_t;

  typedef struct packed {
    kind_t      kind;
    logic       enc_clk;
    logic       enc_dt;
    logic       enc_switch;
    logic [3:0] buttons;
  } cmd_t;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 7;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COARSE_STEP = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPEED_BASE  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPEED_MAX   = 2'd2;

  localparam logic [6:0] COARSE_STEP_RESET = 7'd10;
  localparam logic [3:0] SPEED_BASE_RESET  = 4'd10;
  localparam logic [3:0] SPEED_MAX_RESET   = 4'd9;

endpackage

// ----- sv/edsc_front.sv -----
module edsc_front (
  input  logic              in_valid,
  input  logic [1:0]        mode,
  input  logic              enc_clk,
  input  logic              enc_dt,
  input  logic              enc_switch_pressed,
  input  logic [3:0]        buttons_pressed,
  input  logic              q_full,
  output logic              in_stall,
  output logic              push,
  output edsc_pkg::cmd_t    cmd
);
  import edsc_pkg::*;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // classify the event and keep only the fields its kind uses
  always_comb begin
    cmd = '0;
    cmd.kind = kind_t'(mode);
    unique case (cmd.kind)
      KIND_ENC: begin
        cmd.enc_clk    = enc_clk;
        cmd.enc_dt     = enc_dt;
        cmd.enc_switch = enc_switch_pressed;
      end
      KIND_BTN:  cmd.buttons = buttons_pressed;
      KIND_TICK: ;
      KIND_NONE: ;
      default:   ;
    endcase
  end

endmodule

// ----- sv/edsc_queue.sv -----
module edsc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  edsc_pkg::cmd_t cmd_in,
  input  logic           pop,
  output edsc_pkg::cmd_t cmd_out,
  output logic           q_valid,
  output logic           full
);
  import edsc_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign cmd_out = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue fill out of range");
  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (fill == $past(fill) - 2'd1))
    else $error("queue fill did not drop on pop");

endmodule

// ----- sv/edsc_back.sv -----
module edsc_back (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_write_en,
  input  logic [edsc_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [edsc_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
  input  logic                                     q_valid,
  input  edsc_pkg::cmd_t                           cmd,
  output logic                                     pop,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [3:0]                               coil_drive,
  output logic signed [15:0]                       display_value,
  output logic [1:0]                               run_mode,
  output logic signed [15:0]                       position,
  output logic signed [15:0]                       target_position
);
  import edsc_pkg::*;

  localparam int SW = COUNT_WIDTH + 2;
  localparam logic signed [SW-1:0] SPEED_LO = SW'(1);
  localparam logic signed [SW-1:0] SPEED_HI = SW'(15);

  logic [6:0] coarse_step;
  logic [3:0] speed_base;
  logic [3:0] speed_max;

  run_t       run_reg, run_next;
  count_t     cnt, cnt_next;
  count_t     target, target_next;
  count_t     pos, pos_next;
  logic [2:0] phase, phase_next;
  logic       last_clk, last_clk_next;
  logic [3:0] coil, coil_next;
  logic [3:0] countdown, countdown_next;

  count_t                 step;
  count_t                 cnt_max;
  logic signed [SW-1:0]   speed;
  logic signed [SW-1:0]   speed_sat;

  function automatic logic [2:0] phase_up(input logic [2:0] p);
    return (p >= 3'd1 && p <= 3'd3) ? p + 3'd1 : 3'd1;
  endfunction

  function automatic logic [2:0] phase_down(input logic [2:0] p);
    return (p >= 3'd2 && p <= 3'd4) ? p - 3'd1 : 3'd4;
  endfunction

  // phase outside one to four leaves the coils as they are
  function automatic logic [3:0] drive(input logic [2:0] p, input logic [3:0] c);
    logic [3:0] r;
    r = c;
    if (p >= 3'd1 && p <= 3'd4) begin
      r = 4'b0001 << (p - 3'd1);
    end
    return r;
  endfunction

  assign pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    run_next       = run_reg;
    cnt_next       = cnt;
    target_next    = target;
    pos_next       = pos;
    phase_next     = phase;
    last_clk_next  = last_clk;
    coil_next      = coil;
    countdown_next = countdown;
    step    = (cmd.enc_switch && run_reg == RUN_POSITION) ? count_t'(coarse_step) : count_t'(1);
    cnt_max = count_t'(speed_max);
    speed   = $signed({2'b00, count_t'(speed_base)})
            - $signed({cnt[COUNT_WIDTH-1], cnt[COUNT_WIDTH-1], cnt});
    if (speed < SPEED_LO) begin
      speed_sat = SPEED_LO;
    end else if (speed > SPEED_HI) begin
      speed_sat = SPEED_HI;
    end else begin
      speed_sat = speed;
    end

    unique case (cmd.kind)
      KIND_ENC: begin
        if (cmd.enc_clk != last_clk) begin
          if (!cmd.enc_clk) begin
            cnt_next = cmd.enc_dt ? cnt - step : cnt + step;
          end
          target_next = cnt_next;
        end
        // clamp after the target copy, on every sample in a run mode
        if (run_reg == RUN_CW || run_reg == RUN_CCW) begin
          if ($signed(cnt_next) > $signed(cnt_max)) begin
            cnt_next = cnt_max;
          end else if (cnt_next[COUNT_WIDTH-1]) begin
            cnt_next = '0;
          end
        end
        last_clk_next = cmd.enc_clk;
      end
      KIND_BTN: begin
        if (cmd.buttons[0]) begin
          run_next    = RUN_POSITION;
          cnt_next    = '0;
          pos_next    = '0;
          target_next = '0;
        end
        if (cmd.buttons[1]) begin
          run_next = RUN_CW;
          cnt_next = '0;
        end
        if (cmd.buttons[2]) begin
          run_next = RUN_CCW;
          cnt_next = '0;
        end
        if (cmd.buttons[3]) begin
          run_next = RUN_STOP;
        end
      end
      KIND_TICK: begin
        if (run_reg == RUN_POSITION) begin
          if ($signed(target) > $signed(pos)) begin
            pos_next   = pos + count_t'(1);
            phase_next = phase_up(phase);
            coil_next  = drive(phase_next, coil);
          end else if ($signed(target) < $signed(pos)) begin
            pos_next   = pos - count_t'(1);
            phase_next = phase_down(phase);
            coil_next  = drive(phase_next, coil);
          end
        end else if (run_reg == RUN_CW || run_reg == RUN_CCW) begin
          if (countdown == 4'd0) begin
            // drive the current phase, then advance
            coil_next      = drive(phase, coil);
            phase_next     = (run_reg == RUN_CW) ? phase_up(phase) : phase_down(phase);
            countdown_next = 4'(speed_sat - SPEED_LO);
          end else begin
            countdown_next = countdown - 4'd1;
          end
        end
      end
      KIND_NONE: ;
      default: ;
    endcase

    if (run_next == RUN_STOP) begin
      coil_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      coil_drive      <= coil_next;
      display_value   <= (run_next == RUN_STOP) ? 16'sd0 : 16'(cnt_next);
      run_mode        <= run_next;
      position        <= 16'(pos_next);
      target_position <= 16'(target_next);
    end
    if (rst) begin
      coarse_step <= COARSE_STEP_RESET;
      speed_base  <= SPEED_BASE_RESET;
      speed_max   <= SPEED_MAX_RESET;
      run_reg     <= RUN_POSITION;
      cnt         <= '0;
      target      <= '0;
      pos         <= '0;
      phase       <= 3'd0;
      last_clk    <= 1'b1;
      coil        <= 4'd0;
      countdown   <= 4'd0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          CFG_COARSE_STEP: coarse_step <= cfg_data;
          CFG_SPEED_BASE:  speed_base  <= cfg_data[3:0];
          CFG_SPEED_MAX:   speed_max   <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (pop) begin
        run_reg   <= run_next;
        cnt       <= cnt_next;
        target    <= target_next;
        pos       <= pos_next;
        phase     <= phase_next;
        last_clk  <= last_clk_next;
        coil      <= coil_next;
        countdown <= countdown_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_coil_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(coil_drive))
    else $error("coil drive not one-hot");
  a_stop_released: assert property (@(posedge clk) disable iff (rst)
    (out_valid && run_mode == RUN_STOP) |-> (coil_drive == 4'd0 && display_value == 16'sd0))
    else $error("stop mode result not released");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(position) && $stable(coil_drive)))
    else $error("stalled result lost");

endmodule

// ----- sv/encoder_driven_stepper_controller.sv -----
// Path: an item accepted into the queue is popped by the state update, which
//   loads the output register with its result.
// Throughput: one item per cycle unless stalled; the back end updates the whole
//   motor state at once; the two-entry queue takes items while a result stalls.
// Reset (rst, synchronous): position mode, counts, phase and coils cleared,
//   queue empty, no result valid; registers return to 10, 10 and 9.
module encoder_driven_stepper_controller (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_en,
  input  logic [edsc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [edsc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           mode,
  input  logic                                 enc_clk,
  input  logic                                 enc_dt,
  input  logic                                 enc_switch_pressed,
  input  logic [3:0]                           buttons_pressed,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [3:0]                           coil_drive,
  output logic signed [15:0]                   display_value,
  output logic [1:0]                           run_mode,
  output logic signed [15:0]                   position,
  output logic signed [15:0]                   target_position
);
  import edsc_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic push;
  logic pop;
  logic q_valid;
  logic q_full;

  edsc_front u_front (
    .in_valid           (in_valid),
    .mode               (mode),
    .enc_clk            (enc_clk),
    .enc_dt             (enc_dt),
    .enc_switch_pressed (enc_switch_pressed),
    .buttons_pressed    (buttons_pressed),
    .q_full             (q_full),
    .in_stall           (in_stall),
    .push               (push),
    .cmd                (front_cmd)
  );

  edsc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (front_cmd),
    .pop     (pop),
    .cmd_out (back_cmd),
    .q_valid (q_valid),
    .full    (q_full)
  );

  edsc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_valid         (q_valid),
    .cmd             (back_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .coil_drive      (coil_drive),
    .display_value   (display_value),
    .run_mode        (run_mode),
    .position        (position),
    .target_position (target_position)
  );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import edsc_pkg::*;

  typedef struct packed {
    logic [3:0]  coil;
    logic [15:0] disp;
    run_t        run;
    logic [15:0] pos;
    logic [15:0] tgt;
  } motor_view_t;

  typedef struct packed {
    kind_t       kind;
    logic        enc_clk;
    logic        enc_dt;
    logic        enc_sw;
    logic [3:0]  btn;
    logic        typed;
    logic [3:0]  coil;
    logic [15:0] disp;
    run_t        run;
    logic [15:0] pos;
    logic [15:0] tgt;
  } table_row_t;

  // Rows with typed set carry their expected view; the rest use the predictor.
  // Register values are the reset ones: coarse 10, base 10, max 9.
  localparam table_row_t ITEM_TABLE [28] = '{
    '{KIND_NONE, 1'b1, 1'b1, 1'b1, 4'hF, 1'b1, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_ENC,  1'b1, 1'b0, 1'b0, 4'h0, 1'b1, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_ENC,  1'b0, 1'b0, 1'b0, 4'h0, 1'b1, 4'h0, 16'd1,  RUN_POSITION, 16'd0, 16'd1},
    '{KIND_BTN,  1'b0, 1'b0, 1'b0, 4'h4, 1'b1, 4'h0, 16'd0,  RUN_CCW,      16'd0, 16'd1},
    // phase still unset: coils stay off, phase drops to four
    '{KIND_TICK, 1'b0, 1'b0, 1'b0, 4'h0, 1'b1, 4'h0, 16'd0,  RUN_CCW,      16'd0, 16'd1},
    '{KIND_TICK, 1'b1, 1'b1, 1'b1, 4'hF, 1'b0, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_BTN,  1'b0, 1'b0, 1'b0, 4'h1, 1'b1, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_ENC,  1'b1, 1'b1, 1'b1, 4'h0, 1'b0, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_ENC,  1'b0, 1'b0, 1'b1, 4'h0, 1'b1, 4'h0, 16'd10, RUN_POSITION, 16'd0, 16'd10},
    '{KIND_TICK, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_ENC,  1'b1, 1'b1, 1'b0, 4'h0, 1'b0, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_ENC,  1'b0, 1'b1, 1'b1, 4'h0, 1'b0, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_ENC,  1'b1, 1'b1, 1'b0, 4'h0, 1'b0, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_ENC,  1'b0, 1'b1, 1'b0, 4'h0, 1'b0, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_TICK, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_TICK, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_TICK, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_BTN,  1'b0, 1'b0, 1'b0, 4'h2, 1'b0, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    // count goes below zero in a run mode: target takes it, count clamps
    '{KIND_ENC,  1'b1, 1'b1, 1'b0, 4'h0, 1'b0, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_ENC,  1'b0, 1'b1, 1'b0, 4'h0, 1'b0, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_ENC,  1'b1, 1'b0, 1'b1, 4'h0, 1'b0, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_ENC,  1'b0, 1'b0, 1'b1, 4'h0, 1'b0, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_TICK, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_TICK, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_BTN,  1'b0, 1'b0, 1'b0, 4'h8, 1'b0, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_TICK, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0},
    '{KIND_BTN,  1'b0, 1'b0, 1'b0, 4'hF, 1'b1, 4'h0, 16'd0,  RUN_STOP,     16'd0, 16'd0},
    '{KIND_BTN,  1'b0, 1'b0, 1'b0, 4'h1, 1'b1, 4'h0, 16'd0,  RUN_POSITION, 16'd0, 16'd0}
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write_en = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 mode = '0;
  logic                       enc_clk = 1'b1;
  logic                       enc_dt = 1'b0;
  logic                       enc_switch_pressed = 1'b0;
  logic [3:0]                 buttons_pressed = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [3:0]                 coil_drive;
  logic signed [15:0]         display_value;
  logic [1:0]                 run_mode;
  logic signed [15:0]         position;
  logic signed [15:0]         target_position;

  encoder_driven_stepper_controller DUT (
    .clk                (clk),
    .rst                (rst),
    .cfg_write_en       (cfg_write_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .mode               (mode),
    .enc_clk            (enc_clk),
    .enc_dt             (enc_dt),
    .enc_switch_pressed (enc_switch_pressed),
    .buttons_pressed    (buttons_pressed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .coil_drive         (coil_drive),
    .display_value      (display_value),
    .run_mode           (run_mode),
    .position           (position),
    .target_position    (target_position)
  );

  // motor state as the predictor sees it
  run_t       st_mode;
  count_t     st_count, st_target, st_pos;
  logic [2:0] st_phase;
  logic       st_last_clk;
  logic [3:0] st_coil, st_countdown;
  logic [6:0] cfg_coarse;
  logic [3:0] cfg_base, cfg_max;

  motor_view_t pending_views [$];
  motor_view_t got_view, want_view;
  int mismatches = 0;
  int views_checked = 0;
  int items_sent = 0;
  int settings_written = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic holdoff_req = 1'b0;
  logic holdoff_seen = 1'b0;
  int holdoff_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [2:0] next_phase(logic [2:0] p, logic up);
    if (up) return (p >= 3'd1 && p <= 3'd3) ? p + 3'd1 : 3'd1;
    return (p >= 3'd2 && p <= 3'd4) ? p - 3'd1 : 3'd4;
  endfunction

  function automatic void drive_coils(logic [2:0] p);
    if (p >= 3'd1 && p <= 3'd4) st_coil = 4'b0001 << (p - 3'd1);
  endfunction

  function automatic motor_view_t step_motor(cmd_t c);
    count_t      delta;
    int          ticks;
    motor_view_t v;
    case (c.kind)
      KIND_ENC: begin
        if (c.enc_clk != st_last_clk) begin
          if (!c.enc_clk) begin
            delta = (c.enc_switch && st_mode == RUN_POSITION) ? count_t'(cfg_coarse) : count_t'(1);
            st_count = c.enc_dt ? st_count - delta : st_count + delta;
          end
          st_target = st_count;
        end
        if (st_mode == RUN_CW || st_mode == RUN_CCW) begin
          if ($signed(st_count) > $signed(count_t'(cfg_max))) st_count = count_t'(cfg_max);
          else if ($signed(st_count) < 0) st_count = '0;
        end
        st_last_clk = c.enc_clk;
      end
      KIND_BTN: begin
        if (c.buttons[0]) begin
          st_mode = RUN_POSITION;
          st_count = '0;
          st_pos = '0;
          st_target = '0;
        end
        if (c.buttons[1]) begin
          st_mode = RUN_CW;
          st_count = '0;
        end
        if (c.buttons[2]) begin
          st_mode = RUN_CCW;
          st_count = '0;
        end
        if (c.buttons[3]) st_mode = RUN_STOP;
      end
      KIND_TICK: begin
        if (st_mode == RUN_POSITION) begin
          if ($signed(st_target) > $signed(st_pos)) begin
            st_pos = st_pos + count_t'(1);
            st_phase = next_phase(st_phase, 1'b1);
            drive_coils(st_phase);
          end else if ($signed(st_target) < $signed(st_pos)) begin
            st_pos = st_pos - count_t'(1);
            st_phase = next_phase(st_phase, 1'b0);
            drive_coils(st_phase);
          end
        end else if (st_mode == RUN_CW || st_mode == RUN_CCW) begin
          if (st_countdown == 4'd0) begin
            ticks = int'(cfg_base) - int'($signed(st_count));
            if (ticks < 1) ticks = 1;
            if (ticks > 15) ticks = 15;
            // run modes drive the current phase, then advance it
            drive_coils(st_phase);
            st_phase = next_phase(st_phase, st_mode == RUN_CW);
            st_countdown = 4'(ticks - 1);
          end else begin
            st_countdown = st_countdown - 4'd1;
          end
        end
      end
      default: ;
    endcase
    if (st_mode == RUN_STOP) st_coil = 4'h0;
    v.coil = st_coil;
    v.disp = (st_mode == RUN_STOP) ? 16'd0 : st_count[15:0];
    v.run  = st_mode;
    v.pos  = st_pos[15:0];
    v.tgt  = st_target[15:0];
    return v;
  endfunction

  function automatic cmd_t make_cmd(kind_t k, logic ck, logic dt, logic sw, logic [3:0] b);
    cmd_t c;
    c.kind = k;
    c.enc_clk = ck;
    c.enc_dt = dt;
    c.enc_switch = sw;
    c.buttons = b;
    return c;
  endfunction

  // Mostly encoder edges and ticks so the motor keeps moving; some buttons and noise.
  function automatic cmd_t rand_item();
    int   pick, bsel;
    logic ck;
    logic [3:0] b;
    pick = $urandom_range(99);
    bsel = $urandom_range(99);
    ck = ($urandom_range(9) < 8) ? ~st_last_clk : st_last_clk;
    if (bsel < 60) b = 4'b0001 << $urandom_range(2);
    else if (bsel < 75) b = 4'b1000;
    else b = 4'($urandom_range(15));
    if (pick < 45) return make_cmd(KIND_ENC, ck, 1'($urandom), 1'($urandom), 4'($urandom));
    if (pick < 80) return make_cmd(KIND_TICK, 1'($urandom), 1'($urandom), 1'($urandom), b);
    if (pick < 94) return make_cmd(KIND_BTN, 1'($urandom), 1'($urandom), 1'($urandom), b);
    return make_cmd(KIND_NONE, 1'($urandom), 1'($urandom), 1'($urandom), 4'($urandom));
  endfunction

  task automatic send_item(input cmd_t c, input logic typed, input motor_view_t typed_view);
    motor_view_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= c.kind;
    enc_clk <= c.enc_clk;
    enc_dt <= c.enc_dt;
    enc_switch_pressed <= c.enc_switch;
    buttons_pressed <= c.buttons;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    v = step_motor(c);
    items_sent++;
    pending_views.push_back(typed ? typed_view : v);
  endtask

  // Drop valid and wait until every expected view has come back.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [6:0] coarse, input logic [3:0] base,
                           input logic [3:0] max_lvl);
    cfg_write_en <= 1'b1;
    cfg_index <= CFG_COARSE_STEP;
    cfg_data <= coarse;
    @(posedge clk);
    cfg_index <= CFG_SPEED_BASE;
    cfg_data <= {3'b000, base};
    @(posedge clk);
    cfg_index <= CFG_SPEED_MAX;
    cfg_data <= {3'b000, max_lvl};
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cfg_coarse = coarse;
    cfg_base = base;
    cfg_max = max_lvl;
    settings_written++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_view.coil = coil_drive;
        got_view.disp = display_value;
        got_view.run  = run_t'(run_mode);
        got_view.pos  = position;
        got_view.tgt  = target_position;
        if (pending_views.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result coil=%h disp=%0d mode=%0d pos=%0d tgt=%0d",
                     $time, coil_drive, display_value, run_mode, position, target_position);
        end else begin
          want_view = pending_views.pop_front();
          views_checked++;
          if (got_view.coil !== want_view.coil || got_view.disp !== want_view.disp ||
              got_view.run !== want_view.run || got_view.pos !== want_view.pos ||
              got_view.tgt !== want_view.tgt) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: want %h/%0d/%0d/%0d/%0d got %h/%0d/%0d/%0d/%0d",
                       $time, want_view.coil, $signed(want_view.disp), want_view.run,
                       $signed(want_view.pos), $signed(want_view.tgt), coil_drive,
                       display_value, run_mode, position, target_position);
          end
        end
      end
      if (holdoff_req != holdoff_seen) begin
        holdoff_seen = holdoff_req;
        holdoff_left = 120;
      end
      if (holdoff_left > 0) begin
        out_stall <= 1'b1;
        holdoff_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    table_row_t  row;
    motor_view_t tv;
    st_mode = RUN_POSITION;
    st_count = '0;
    st_target = '0;
    st_pos = '0;
    st_phase = 3'd0;
    st_last_clk = 1'b1;
    st_coil = 4'h0;
    st_countdown = 4'h0;
    cfg_coarse = COARSE_STEP_RESET;
    cfg_base = SPEED_BASE_RESET;
    cfg_max = SPEED_MAX_RESET;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 29;
    recv_idle_pct = 86;
    for (int i = 0; i < 28; i++) begin
      row = ITEM_TABLE[i];
      tv.coil = row.coil;
      tv.disp = row.disp;
      tv.run = row.run;
      tv.pos = row.pos;
      tv.tgt = row.tgt;
      send_item(make_cmd(row.kind, row.enc_clk, row.enc_dt, row.enc_sw, row.btn), row.typed, tv);
    end

    for (int ph = 0; ph < 6; ph++) begin
      settle_block();
      case (ph)
        0: configure(7'd100, 4'd15, 4'd0);
        1: configure(7'd1, 4'd1, 4'd14);
        default: configure(7'($urandom_range(1, 100)), 4'($urandom_range(1, 15)),
                           4'($urandom_range(0, 14)));
      endcase
      send_idle_pct = (ph < 2) ? 29 : (ph < 4) ? 86 : 0;
      recv_idle_pct = (ph < 2) ? 86 : (ph < 4) ? 29 : 0;
      for (int n = 0; n < 60; n++) begin
        if (ph == 2 && n == 40) settle_block();
        // long receiver hold-off while the sender keeps pushing
        if (ph == 4 && n == 20) holdoff_req <= ~holdoff_req;
        send_item(rand_item(), 1'b0, '0);
      end
    end

    // Climb the count with coarse steps, ticking along.
    settle_block();
    configure(7'd100, 4'($urandom_range(1, 15)), 4'($urandom_range(0, 14)));
    send_item(make_cmd(KIND_BTN, 1'b0, 1'b0, 1'b0, 4'b0001), 1'b0, '0);
    for (int k = 0; k < 40; k++) begin
      send_item(make_cmd(KIND_ENC, 1'b1, 1'b0, 1'b1, 4'($urandom)), 1'b0, '0);
      send_item(make_cmd(KIND_ENC, 1'b0, 1'b0, 1'b1, 4'($urandom)), 1'b0, '0);
      if (k % 4 == 3) send_item(make_cmd(KIND_TICK, 1'b0, 1'b0, 1'b0, 4'h0), 1'b0, '0);
    end

    settle_block();
    repeat (6) @(posedge clk);
    $display("Covered %0d items: directed table, six random phases, coarse sweep, %0d settings",
             items_sent, settings_written);
    $display("Checked %0d results, %0d mismatches", views_checked, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- encoder_driven_stepper_controller.f -----
sv/edsc_pkg.sv
sv/edsc_front.sv
sv/edsc_queue.sv
sv/edsc_back.sv
sv/encoder_driven_stepper_controller.sv
dv/tb_top.sv
